@@ rtl/core/olr_pkg.sv @@
// ----------------------------------------------------------------------------
// olr_pkg
// Shared types and codes of the overwrite-oldest line ring: input modes,
// queued command layout, result kinds, push status codes and back-end states.
// ----------------------------------------------------------------------------
`default_nettype none

package olr_pkg;

   localparam logic [1:0] MODE_PUSH  = 2'd0;
   localparam logic [1:0] MODE_FRAME = 2'd1;
   localparam logic [1:0] MODE_POP   = 2'd2;

   localparam logic [1:0] KIND_STATUS    = 2'd0;
   localparam logic [1:0] KIND_BYTE      = 2'd1;
   localparam logic [1:0] KIND_FRAME_END = 2'd2;

   localparam logic [1:0] STATUS_STORED    = 2'd0;
   localparam logic [1:0] STATUS_OVERWRITE = 2'd1;
   localparam logic [1:0] STATUS_DROPPED   = 2'd2;

   localparam logic [7:0] NEWLINE_BYTE = 8'd10;

   localparam int STORED_W    = 9;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPW         = $clog2(QUEUE_DEPTH);
   localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_PUSH,
      OP_PUSH_END,
      OP_FRAME,
      OP_POP
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  data_byte;
      logic        write_en;
      logic [7:0]  offset;
      logic        too_long;
      logic [7:0]  line_len;
      logic [15:0] capacity;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_STREAM
   } back_state_type;

endpackage

`default_nettype wire

@@ rtl/core/olr_front.sv @@
// ----------------------------------------------------------------------------
// olr_front
// Input side: accepts request transfers, tracks the staging line length and
// overflow, and turns each item into a command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module olr_front #(
   parameter int SLOT_BYTES = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_mode,
   input  wire logic [7:0]        req_data_byte,
   input  wire logic              req_end_of_line,
   input  wire logic [15:0]       req_frame_capacity,
   output logic                   cmd_valid,
   output olr_pkg::cmd_type       cmd,
   input  wire logic              cmd_ready
);

   localparam int SW = $clog2(SLOT_BYTES + 1);
   localparam logic [SW-1:0] SB_S = SW'(SLOT_BYTES);

   logic [SW-1:0] st_len_ff, st_len_in;
   logic          st_ovf_ff, st_ovf_in;
   logic          accept;
   logic          wr_ok;
   logic [SW-1:0] len_next;
   logic          ovf_next;

   assign req_ready = cmd_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      wr_ok     = st_len_ff < SB_S;
      len_next  = wr_ok ? st_len_ff + SW'(1) : st_len_ff;
      ovf_next  = st_ovf_ff || !wr_ok;
      st_len_in = st_len_ff;
      st_ovf_in = st_ovf_ff;
      cmd_valid = 1'b0;

      cmd.op        = olr_pkg::OP_PUSH;
      cmd.data_byte = req_data_byte;
      cmd.write_en  = wr_ok;
      cmd.offset    = 8'(st_len_ff);
      cmd.too_long  = ovf_next || (len_next >= SB_S);
      cmd.line_len  = 8'(len_next);
      cmd.capacity  = req_frame_capacity;

      unique case (req_mode)
         olr_pkg::MODE_PUSH: begin
            cmd_valid = req_valid;
            if (req_end_of_line) begin
               cmd.op = olr_pkg::OP_PUSH_END;
               if (accept) begin
                  st_len_in = '0;
                  st_ovf_in = 1'b0;
               end
            end else if (accept) begin
               st_len_in = len_next;
               st_ovf_in = ovf_next;
            end
         end
         olr_pkg::MODE_FRAME: begin
            cmd.op    = olr_pkg::OP_FRAME;
            cmd_valid = req_valid;
         end
         olr_pkg::MODE_POP: begin
            cmd.op    = olr_pkg::OP_POP;
            cmd_valid = req_valid;
         end
         default: begin
            cmd_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_len_ff <= '0;
         st_ovf_ff <= 1'b0;
      end else begin
         st_len_ff <= st_len_in;
         st_ovf_ff <= st_ovf_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/olr_cmd_queue.sv @@
// ----------------------------------------------------------------------------
// olr_cmd_queue
// Short command queue between front and back end, so each side can stall
// on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module olr_cmd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire olr_pkg::cmd_type  in_cmd,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output olr_pkg::cmd_type       out_cmd
);

   localparam int QPW = olr_pkg::QPW;
   localparam int QCW = olr_pkg::QCW;

   olr_pkg::cmd_type entry_ff [olr_pkg::QUEUE_DEPTH];
   logic [QPW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]   count_ff, count_in;
   logic             push;
   logic             pop;

   assign in_ready  = count_ff != QCW'(olr_pkg::QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_cmd   = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPW'(olr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPW'(olr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/olr_back.sv @@
// ----------------------------------------------------------------------------
// olr_back
// Execution side: record and length memories, ring pointers, drop and frame
// counters, pop sequencer and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module olr_back #(
   parameter int SLOTS      = 16,
   parameter int SLOT_BYTES = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   output logic                   cmd_ready,
   input  wire olr_pkg::cmd_type  cmd,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [1:0]             rsp_kind,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_last,
   output logic [1:0]             rsp_push_status,
   output logic [31:0]            rsp_drop_total,
   output logic [15:0]            rsp_frame_lines,
   output logic [15:0]            rsp_frame_bytes,
   output logic [olr_pkg::STORED_W-1:0] rsp_stored_count
);

   localparam int REGIONS   = SLOTS + 1;
   localparam int MEM_DEPTH = REGIONS * SLOT_BYTES;
   localparam int AW        = $clog2(MEM_DEPTH);
   localparam int RW        = $clog2(REGIONS);
   localparam int HW        = $clog2(SLOTS + 1);
   localparam int LW        = $clog2(SLOT_BYTES);
   localparam logic [AW-1:0] SB_A   = AW'(SLOT_BYTES);
   localparam logic [RW-1:0] LAST_R = RW'(SLOTS);
   localparam logic [HW-1:0] FULL_H = HW'(SLOTS);

   logic [7:0]    rec_mem [MEM_DEPTH];
   logic [LW-1:0] len_mem [REGIONS];

   olr_pkg::back_state_type state_ff, state_in;

   logic [RW-1:0] head_ff, head_in;
   logic [RW-1:0] tail_ff, tail_in;
   logic [HW-1:0] held_ff, held_in;
   logic [31:0]   drop_ff, drop_in;
   logic [15:0]   budget_ff, budget_in;
   logic [15:0]   used_ff, used_in;
   logic [15:0]   lines_ff, lines_in;
   logic [LW-1:0] n_ff, n_in;
   logic [LW-1:0] iss_ff, iss_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] base_ff, base_in;

   logic [7:0]    rd_data_ff;
   logic [LW-1:0] len_rd_ff;

   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic          mem_re;
   logic [AW-1:0] mem_ra;
   logic          len_we;

   logic          out_free;
   logic          out_load;
   logic [1:0]    out_kind;
   logic [7:0]    out_byte;
   logic          out_last;
   logic [1:0]    out_status;

   logic          consume;
   logic [16:0]   need;
   logic          fits;

   logic          rsp_valid_ff;
   logic [1:0]    rsp_kind_ff;
   logic [7:0]    rsp_out_byte_ff;
   logic          rsp_last_ff;
   logic [1:0]    rsp_push_status_ff;
   logic [31:0]   rsp_drop_total_ff;
   logic [15:0]   rsp_frame_lines_ff;
   logic [15:0]   rsp_frame_bytes_ff;
   logic [olr_pkg::STORED_W-1:0] rsp_stored_count_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign mem_wa   = AW'(head_ff) * SB_A + AW'(LW'(cmd.offset));
   assign mem_ra   = base_ff + AW'(iss_ff);
   assign need     = 17'(used_ff) + 17'(len_rd_ff) + 17'd1;
   assign fits     = (held_ff != '0) && (need <= 17'(budget_ff));
   assign consume  = pend_ff && out_free;

   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      held_in    = held_ff;
      drop_in    = drop_ff;
      budget_in  = budget_ff;
      used_in    = used_ff;
      lines_in   = lines_ff;
      n_in       = n_ff;
      iss_in     = iss_ff;
      pend_in    = pend_ff;
      base_in    = base_ff;
      cmd_ready  = 1'b0;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      len_we     = 1'b0;
      out_load   = 1'b0;
      out_kind   = olr_pkg::KIND_STATUS;
      out_byte   = 8'd0;
      out_last   = 1'b0;
      out_status = olr_pkg::STATUS_STORED;

      unique case (state_ff)
         olr_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.op)
                  olr_pkg::OP_PUSH: begin
                     cmd_ready = 1'b1;
                     mem_we    = cmd.write_en;
                  end
                  olr_pkg::OP_PUSH_END: begin
                     if (out_free) begin
                        cmd_ready = 1'b1;
                        mem_we    = cmd.write_en;
                        out_load  = 1'b1;
                        out_last  = 1'b1;
                        if (cmd.too_long) begin
                           out_status = olr_pkg::STATUS_DROPPED;
                           drop_in    = drop_ff + 32'd1;
                        end else begin
                           len_we  = 1'b1;
                           head_in = (head_ff == LAST_R) ? '0 : head_ff + RW'(1);
                           if (held_ff < FULL_H) begin
                              held_in    = held_ff + HW'(1);
                              out_status = olr_pkg::STATUS_STORED;
                           end else begin
                              tail_in    = (tail_ff == LAST_R) ? '0 : tail_ff + RW'(1);
                              drop_in    = drop_ff + 32'd1;
                              out_status = olr_pkg::STATUS_OVERWRITE;
                           end
                        end
                     end
                  end
                  olr_pkg::OP_FRAME: begin
                     cmd_ready = 1'b1;
                     budget_in = cmd.capacity;
                     used_in   = 16'd0;
                     lines_in  = 16'd0;
                  end
                  olr_pkg::OP_POP: begin
                     cmd_ready = 1'b1;
                     state_in  = olr_pkg::ST_CHECK;
                  end
                  default: begin
                     cmd_ready = 1'b1;
                  end
               endcase
            end
         end
         olr_pkg::ST_CHECK: begin
            if (fits) begin
               held_in  = held_ff - HW'(1);
               tail_in  = (tail_ff == LAST_R) ? '0 : tail_ff + RW'(1);
               used_in  = 16'(need);
               lines_in = lines_ff + 16'd1;
               n_in     = len_rd_ff;
               iss_in   = '0;
               pend_in  = 1'b0;
               base_in  = AW'(tail_ff) * SB_A;
               state_in = olr_pkg::ST_STREAM;
            end else if (out_free) begin
               out_load = 1'b1;
               out_kind = olr_pkg::KIND_FRAME_END;
               out_last = 1'b1;
               state_in = olr_pkg::ST_IDLE;
            end
         end
         olr_pkg::ST_STREAM: begin
            if (consume) begin
               out_load = 1'b1;
               out_kind = olr_pkg::KIND_BYTE;
               out_byte = rd_data_ff;
               pend_in  = 1'b0;
            end
            if ((iss_ff != n_ff) && (!pend_ff || consume)) begin
               mem_re  = 1'b1;
               iss_in  = iss_ff + LW'(1);
               pend_in = 1'b1;
            end
            if ((iss_ff == n_ff) && !pend_ff && out_free) begin
               out_load = 1'b1;
               out_kind = olr_pkg::KIND_BYTE;
               out_byte = olr_pkg::NEWLINE_BYTE;
               out_last = 1'b1;
               state_in = olr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = olr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= olr_pkg::ST_IDLE;
         head_ff   <= '0;
         tail_ff   <= '0;
         held_ff   <= '0;
         drop_ff   <= '0;
         budget_ff <= '0;
         used_ff   <= '0;
         lines_ff  <= '0;
         n_ff      <= '0;
         iss_ff    <= '0;
         pend_ff   <= 1'b0;
         base_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         held_ff   <= held_in;
         drop_ff   <= drop_in;
         budget_ff <= budget_in;
         used_ff   <= used_in;
         lines_ff  <= lines_in;
         n_ff      <= n_in;
         iss_ff    <= iss_in;
         pend_ff   <= pend_in;
         base_ff   <= base_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         rec_mem[mem_wa] <= cmd.data_byte;
      end
      if (mem_re) begin
         rd_data_ff <= rec_mem[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[head_ff] <= LW'(cmd.line_len);
      end
      len_rd_ff <= len_mem[tail_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_kind_ff         <= out_kind;
         rsp_out_byte_ff     <= out_byte;
         rsp_last_ff         <= out_last;
         rsp_push_status_ff  <= out_status;
         rsp_drop_total_ff   <= drop_in;
         rsp_frame_lines_ff  <= lines_in;
         rsp_frame_bytes_ff  <= used_in;
         rsp_stored_count_ff <= olr_pkg::STORED_W'(held_in);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_out_byte     = rsp_out_byte_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_push_status  = rsp_push_status_ff;
   assign rsp_drop_total   = rsp_drop_total_ff;
   assign rsp_frame_lines  = rsp_frame_lines_ff;
   assign rsp_frame_bytes  = rsp_frame_bytes_ff;
   assign rsp_stored_count = rsp_stored_count_ff;

endmodule

`default_nettype wire

@@ rtl/core/overwrite_oldest_line_ring_core.sv @@
// ----------------------------------------------------------------------------
// overwrite_oldest_line_ring_core
// Ring of up to SLOTS text lines that overwrites the oldest line when full,
// with framed, byte-budgeted readout.
// ----------------------------------------------------------------------------
// Pushed line bytes are taken one per cycle while the queue has room; a
// closing byte gives one status result. A pop fetches and checks the oldest
// line's length, then issues the first record read, then streams its bytes
// and a closing newline one per cycle while the output is taken, paced by
// the single read port of the record memory; a pop that does not fit
// answers with a frame end. The record memory holds (SLOTS + 1) * SLOT_BYTES
// bytes: one region receives the line being staged, so a line is committed
// without a copy. Nothing is cleared after reset and the block accepts
// items at once. A four-entry command queue lets input be taken while a
// pop streams.
`default_nettype none

module overwrite_oldest_line_ring_core #(
   parameter int SLOTS      = 16,
   parameter int SLOT_BYTES = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_mode,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_end_of_line,
   input  wire logic [15:0] req_frame_capacity,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last,
   output logic [1:0]       rsp_push_status,
   output logic [31:0]      rsp_drop_total,
   output logic [15:0]      rsp_frame_lines,
   output logic [15:0]      rsp_frame_bytes,
   output logic [8:0]       rsp_stored_count
);

   logic             f_valid;
   logic             f_ready;
   olr_pkg::cmd_type f_cmd;
   logic             b_valid;
   logic             b_ready;
   olr_pkg::cmd_type b_cmd;

   olr_front #(
      .SLOT_BYTES(SLOT_BYTES)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_data_byte      (req_data_byte),
      .req_end_of_line    (req_end_of_line),
      .req_frame_capacity (req_frame_capacity),
      .cmd_valid          (f_valid),
      .cmd                (f_cmd),
      .cmd_ready          (f_ready)
   );

   olr_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_cmd    (f_cmd),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_cmd   (b_cmd)
   );

   olr_back #(
      .SLOTS      (SLOTS),
      .SLOT_BYTES (SLOT_BYTES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (b_valid),
      .cmd_ready        (b_ready),
      .cmd              (b_cmd),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last         (rsp_last),
      .rsp_push_status  (rsp_push_status),
      .rsp_drop_total   (rsp_drop_total),
      .rsp_frame_lines  (rsp_frame_lines),
      .rsp_frame_bytes  (rsp_frame_bytes),
      .rsp_stored_count (rsp_stored_count)
   );

endmodule

`default_nettype wire
